// ===== rtl/rcc_pkg.sv =====
package rcc_pkg;

  // Result color codes
  localparam logic [2:0] HUE_NONE   = 3'd0;
  localparam logic [2:0] HUE_RED    = 3'd1;
  localparam logic [2:0] HUE_ORANGE = 3'd2;
  localparam logic [2:0] HUE_YELLOW = 3'd3;
  localparam logic [2:0] HUE_GREEN  = 3'd4;
  localparam logic [2:0] HUE_CYAN   = 3'd5;
  localparam logic [2:0] HUE_BLUE   = 3'd6;
  localparam logic [2:0] HUE_PURPLE = 3'd7;

  // Opcodes
  localparam logic OP_CLASSIFY  = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_WHITE_MIN      = 3'd0;
  localparam logic [2:0] REG_PEAK_MIN       = 3'd1;
  localparam logic [2:0] REG_SATURATION_MIN = 3'd2;
  localparam logic [2:0] REG_STRONG_RISE    = 3'd3;
  localparam logic [2:0] REG_WEAK_RISE      = 3'd4;
  localparam logic [2:0] REG_MILD_FALL      = 3'd5;
  localparam logic [2:0] REG_STRONG_FALL    = 3'd6;

  // Fixed calibration floors
  localparam logic [15:0] CAL_WHITE_FLOOR = 16'd100;
  localparam logic [15:0] CAL_RG_FLOOR    = 16'd30;
  localparam logic [15:0] CAL_B_FLOOR     = 16'd10;

  // Request passed from front to back through the queue
  typedef struct packed {
    logic        opcode;
    logic        early_none;
    logic        cal_valid;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } req_t;

  // Threshold set
  typedef struct packed {
    logic [17:0] saturation_min;
    logic [15:0] strong_rise;
    logic [15:0] weak_rise;
    logic [15:0] mild_fall;
    logic [15:0] strong_fall;
  } thr_t;

endpackage

// ===== rtl/rcc_front.sv =====
module rcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [15:0]         red,
  input  logic [15:0]         green,
  input  logic [15:0]         blue,
  input  logic [15:0]         white,
  input  logic [15:0]         white_min,
  input  logic [15:0]         peak_min,
  output logic                q_valid,
  input  logic                q_ready,
  output rcc_pkg::req_t       q_req
);

  logic [15:0] peak;
  logic        full;

  // Peak channel value for the dark check
  always_comb begin
    peak = (red > green) ? red : green;
    if (blue > peak) peak = blue;
  end

  assign in_ready = !full || q_ready;
  assign q_valid  = full;

  // Hold one request
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_req.opcode     <= opcode;
      q_req.early_none <= (white < white_min) || (peak < peak_min);
      q_req.cal_valid  <= (white > rcc_pkg::CAL_WHITE_FLOOR) &&
                          (red > rcc_pkg::CAL_RG_FLOOR) &&
                          (green > rcc_pkg::CAL_RG_FLOOR) &&
                          (blue > rcc_pkg::CAL_B_FLOOR);
      q_req.red        <= red;
      q_req.green      <= green;
      q_req.blue       <= blue;
    end
  end

endmodule

// ===== rtl/rcc_queue.sv =====
module rcc_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rcc_pkg::req_t wr_req,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rcc_pkg::req_t rd_req
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rcc_pkg::req_t    slots [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_req   = slots[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wp] <= wr_req;
  end

endmodule

// ===== rtl/rcc_divider.sv =====
module rcc_divider #(
  parameter int NW = 40,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  // One quotient bit per cycle, restoring
  assign trial = {rem[DW-1:0], q[NW-1]} - {1'b0, den};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], q[NW-1]};
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/rcc_back.sv =====
module rcc_back #(
  parameter int CAL_SAMPLES     = 8,
  parameter int MIN_VALID       = 3,
  parameter int SHARE_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  rcc_pkg::req_t q_req,
  input  rcc_pkg::thr_t thr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    color,
  output logic          baseline_calibrated,
  output logic          calibration_done
);

  localparam int SW  = SHARE_FRAC_BITS + 1;
  localparam int CNW = $clog2(CAL_SAMPLES + 1);
  localparam int ACW = SW + CNW;
  localparam int NW  = ACW + SHARE_FRAC_BITS;
  localparam int DW  = 18;
  localparam int DVW = (ACW > DW) ? ACW : DW;
  localparam int NUM = (NW > 16 + SHARE_FRAC_BITS) ? NW : 16 + SHARE_FRAC_BITS;
  localparam logic [SW-1:0] BASE_R =
    SW'(((64'd40 << SHARE_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SW-1:0] BASE_G =
    SW'(((64'd39 << SHARE_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SW-1:0] BASE_B =
    SW'(((64'd21 << SHARE_FRAC_BITS) + 64'd50) / 64'd100);
  localparam int DVX = SW + 2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_DEV    = 6'b000100,
    S_DECIDE = 6'b001000,
    S_MEAN   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t         state;
  rcc_pkg::req_t  req;
  logic [1:0]     ch;
  logic [SW-1:0]  share [3];
  logic [SW-1:0]  base  [3];
  logic [ACW-1:0] acc   [3];
  logic [CNW-1:0] sample_index;
  logic [CNW-1:0] valid_samples;
  logic           calibrated_flag;
  logic           launch;
  logic           div_start;
  logic           div_done;
  logic [NUM-1:0] div_num;
  logic [DVW-1:0] div_den;
  logic [NUM-1:0] div_quo;
  logic           mean_mode;
  logic [17:0]    total;
  logic signed [DVX-1:0] dev [3];
  logic [DVX+1:0] sat;
  logic [2:0]     cres;

  assign total = 18'(req.red) + 18'(req.green) + 18'(req.blue);

  // Dividend and divisor for the shared serial divider
  always_comb begin
    logic [15:0] x;
    case (ch)
      2'd0:    x = req.red;
      2'd1:    x = req.green;
      default: x = req.blue;
    endcase
    if (mean_mode) begin
      div_num = NUM'(acc[ch]);
      div_den = DVW'(valid_samples);
    end else begin
      div_num = NUM'({x, {SHARE_FRAC_BITS{1'b0}}});
      div_den = DVW'(total);
    end
  end

  rcc_divider #(.NW(NUM), .DW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Threshold tree over registered deviations
  always_comb begin
    logic signed [DVX-1:0] rd, gd, bd, mx, mn;
    logic signed [DVX-1:0] sr, wr, mf, sf;
    rd = dev[0];
    gd = dev[1];
    bd = dev[2];
    sr = DVX'($signed({1'b0, thr.strong_rise}));
    wr = DVX'($signed({1'b0, thr.weak_rise}));
    mf = -DVX'($signed({1'b0, thr.mild_fall}));
    sf = -DVX'($signed({1'b0, thr.strong_fall}));
    mx = (rd > gd) ? rd : gd;
    if (bd > mx) mx = bd;
    mn = (rd < gd) ? rd : gd;
    if (bd < mn) mn = bd;
    if (req.early_none || (sat < (DVX+2)'(thr.saturation_min))) begin
      cres = rcc_pkg::HUE_NONE;
    end else if (rd == mx && rd > sr) begin
      if (bd > sr) cres = rcc_pkg::HUE_PURPLE;
      else if (gd > wr) cres = rcc_pkg::HUE_YELLOW;
      else if (gd > mf) cres = rcc_pkg::HUE_ORANGE;
      else cres = rcc_pkg::HUE_RED;
    end else if (gd == mx && gd > sr) begin
      if (bd > wr) cres = rcc_pkg::HUE_CYAN;
      else if (rd > wr) cres = rcc_pkg::HUE_YELLOW;
      else cres = rcc_pkg::HUE_GREEN;
    end else if (bd == mx && bd > sr) begin
      if (rd > wr) cres = rcc_pkg::HUE_PURPLE;
      else if (gd > wr) cres = rcc_pkg::HUE_CYAN;
      else cres = rcc_pkg::HUE_BLUE;
    end else if (bd == mn && bd < sf) begin
      if (rd > gd && rd > wr) cres = rcc_pkg::HUE_ORANGE;
      else if (gd > rd && gd > wr) cres = rcc_pkg::HUE_GREEN;
      else if (rd > 0 && gd > 0) cres = rcc_pkg::HUE_YELLOW;
      else cres = rcc_pkg::HUE_ORANGE;
    end else if (gd == mn && gd < sf) begin
      if (rd > bd) cres = rcc_pkg::HUE_RED;
      else if (bd > rd) cres = rcc_pkg::HUE_BLUE;
      else cres = rcc_pkg::HUE_PURPLE;
    end else if (rd == mn && rd < sf) begin
      if (gd > bd) cres = rcc_pkg::HUE_GREEN;
      else if (bd > gd) cres = rcc_pkg::HUE_BLUE;
      else cres = rcc_pkg::HUE_CYAN;
    end else begin
      cres = rcc_pkg::HUE_NONE;
    end
  end

  assign q_ready             = (state == S_IDLE);
  assign out_valid           = (state == S_OUT);
  assign baseline_calibrated = calibrated_flag;
  assign div_start           = launch;

  // Launch each division when its request and channel have been registered
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= (state == S_IDLE && q_valid &&
                 (q_req.opcode == rcc_pkg::OP_CLASSIFY || q_req.cal_valid))
             || (state == S_DIV && div_done && ch != 2'd2)
             || (state == S_MEAN && div_done && ch != 2'd2)
             || (state == S_DEV && mean_mode);
    end
  end

  // Steps: three share divisions, deviation or sums, decision, run mean, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ch              <= 2'd0;
      mean_mode       <= 1'b0;
      sample_index    <= '0;
      valid_samples   <= '0;
      calibrated_flag <= 1'b0;
      calibration_done <= 1'b0;
      color           <= rcc_pkg::HUE_NONE;
      base[0]         <= BASE_R;
      base[1]         <= BASE_G;
      base[2]         <= BASE_B;
      for (int i = 0; i < 3; i++) acc[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req       <= q_req;
            ch        <= 2'd0;
            mean_mode <= 1'b0;
            if (q_req.opcode == rcc_pkg::OP_CLASSIFY || q_req.cal_valid) begin
              state <= S_DIV;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            share[ch] <= (total == '0) ? '0 : SW'(div_quo);
            if (ch == 2'd2) state <= S_DEV;
            else ch <= ch + 1'b1;
          end
        end
        S_DEV: begin
          if (mean_mode) begin
            state <= S_MEAN;
          end else if (req.opcode == rcc_pkg::OP_CLASSIFY) begin
            for (int i = 0; i < 3; i++) begin
              dev[i] <= DVX'($signed({1'b0, share[i]})) - DVX'($signed({1'b0, base[i]}));
            end
            state <= S_DECIDE;
          end else begin
            for (int i = 0; i < 3; i++) acc[i] <= acc[i] + ACW'(share[i]);
            valid_samples <= valid_samples + 1'b1;
            state <= S_DECIDE;
          end
          ch <= 2'd0;
        end
        S_DECIDE: begin
          if (req.opcode == rcc_pkg::OP_CLASSIFY) begin
            color            <= cres;
            calibration_done <= 1'b0;
            state            <= S_OUT;
          end else begin
            color <= rcc_pkg::HUE_NONE;
            if (sample_index == CNW'(CAL_SAMPLES - 1)) begin
              calibration_done <= 1'b1;
              sample_index     <= '0;
              if (valid_samples >= CNW'(MIN_VALID) && valid_samples != '0) begin
                mean_mode <= 1'b1;
                ch        <= 2'd0;
                state     <= S_DEV;
              end else begin
                for (int i = 0; i < 3; i++) acc[i] <= '0;
                valid_samples <= '0;
                state         <= S_OUT;
              end
            end else begin
              sample_index     <= sample_index + 1'b1;
              calibration_done <= 1'b0;
              state            <= S_OUT;
            end
          end
        end
        S_MEAN: begin
          if (div_done) begin
            base[ch] <= SW'(div_quo);
            if (ch == 2'd2) begin
              calibrated_flag <= 1'b1;
              for (int i = 0; i < 3; i++) acc[i] <= '0;
              valid_samples <= '0;
              mean_mode     <= 1'b0;
              state         <= S_OUT;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Summed absolute deviation
  always_comb begin
    sat = '0;
    for (int i = 0; i < 3; i++) begin
      sat = sat + (dev[i][DVX-1] ? (DVX+2)'(-dev[i]) : (DVX+2)'(dev[i]));
    end
  end

endmodule

// ===== rtl/rgb_color_classifier_baseline_unit.sv =====
// Each request takes three share divisions on the shared one-bit-per-cycle divider,
// 2 x SHARE_FRAC_BITS + 5 bits wide for eight-sample runs; an invalid calibration sample
// skips them, and a baseline-replacing run end adds three mean divisions. The back end
// takes a new request only after the last result is accepted; the front end and queue
// hold up to three more requests meanwhile.
// Reset (rst, synchronous, active high) restores thresholds, baseline and calibration.
module rgb_color_classifier_baseline_unit #(
  parameter int CAL_SAMPLES     = 8,
  parameter int MIN_VALID       = 3,
  parameter int SHARE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: red[15:0], green[31:16], blue[47:32], white[63:48]
  input  logic [63:0] s_tdata,
  // tuser: opcode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: color[2:0], baseline_calibrated[3], calibration_done[4], zero fill
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  rcc_pkg::thr_t thr;
  logic [15:0]   white_min;
  logic [15:0]   peak_min;
  logic          f_valid, f_ready, b_valid, b_ready;
  rcc_pkg::req_t f_req, b_req;
  logic [2:0]    color;
  logic          cal_flag, cal_done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      white_min          <= 16'd100;
      peak_min           <= 16'd30;
      thr.saturation_min <= 18'd1638;
      thr.strong_rise    <= 16'd328;
      thr.weak_rise      <= 16'd197;
      thr.mild_fall      <= 16'd655;
      thr.strong_fall    <= 16'd524;
    end else if (cfg_we) begin
      case (cfg_index)
        rcc_pkg::REG_WHITE_MIN:      white_min          <= cfg_data[15:0];
        rcc_pkg::REG_PEAK_MIN:       peak_min           <= cfg_data[15:0];
        rcc_pkg::REG_SATURATION_MIN: thr.saturation_min <= cfg_data;
        rcc_pkg::REG_STRONG_RISE:    thr.strong_rise    <= cfg_data[15:0];
        rcc_pkg::REG_WEAK_RISE:      thr.weak_rise      <= cfg_data[15:0];
        rcc_pkg::REG_MILD_FALL:      thr.mild_fall      <= cfg_data[15:0];
        rcc_pkg::REG_STRONG_FALL:    thr.strong_fall    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tuser),
    .red       (s_tdata[15:0]),
    .green     (s_tdata[31:16]),
    .blue      (s_tdata[47:32]),
    .white     (s_tdata[63:48]),
    .white_min (white_min),
    .peak_min  (peak_min),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_req     (f_req)
  );

  rcc_queue #(.DEPTH(2)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_req   (f_req),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_req   (b_req)
  );

  rcc_back #(
    .CAL_SAMPLES     (CAL_SAMPLES),
    .MIN_VALID       (MIN_VALID),
    .SHARE_FRAC_BITS (SHARE_FRAC_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (b_valid),
    .q_ready             (b_ready),
    .q_req               (b_req),
    .thr                 (thr),
    .out_valid           (m_tvalid),
    .out_ready           (m_tready),
    .color               (color),
    .baseline_calibrated (cal_flag),
    .calibration_done    (cal_done)
  );

  assign m_tdata = {3'b000, cal_done, cal_flag, color};

endmodule

// ===== verif/tb_rgb_color_classifier_baseline_unit.sv =====
module tb_rgb_color_classifier_baseline_unit;

  localparam int SHARE_BITS  = 16;
  localparam int RUN_LEN     = 8;
  localparam int RUN_MIN_OK  = 3;
  localparam int DRAIN_WAIT  = 600;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  rgb_color_classifier_baseline_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [2:0] color;
    logic       calibrated;
    logic       run_done;
  } verdict_t;

  typedef struct {
    logic        op;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] white;
    bit          typed;
    logic [2:0]  color;
  } reading_t;

  verdict_t verdict_q[$];
  int       errors;
  longint   cycles;
  int       idle_pct;
  int       stall_pct;
  int       hold_cycles;

  // Thresholds mirrored from the register writes
  longint thr_white, thr_peak, thr_sat, thr_srise, thr_wrise, thr_mfall, thr_sfall;
  // Baseline and calibration run state
  longint base_r, base_g, base_b;
  longint acc_r, acc_g, acc_b;
  int     run_pos, run_ok;
  bit     is_calibrated;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  function automatic longint share(input longint x, input longint total);
    if (total == 0) return 0;
    return (x << SHARE_BITS) / total;
  endfunction

  function automatic logic [2:0] predict_color(input longint r, g, b, w);
    longint peak, total, rd, gd, bd, mx, mn, sat;
    if (w < thr_white) return rcc_pkg::HUE_NONE;
    peak = (r > g) ? r : g;
    if (b > peak) peak = b;
    if (peak < thr_peak) return rcc_pkg::HUE_NONE;
    total = r + g + b;
    rd = share(r, total) - base_r;
    gd = share(g, total) - base_g;
    bd = share(b, total) - base_b;
    sat = (rd < 0 ? -rd : rd) + (gd < 0 ? -gd : gd) + (bd < 0 ? -bd : bd);
    if (sat < thr_sat) return rcc_pkg::HUE_NONE;
    mx = (rd > gd) ? rd : gd;
    if (bd > mx) mx = bd;
    // Dominant rise: red, then green, then blue
    if (rd == mx && rd > thr_srise) begin
      if (bd > thr_srise) return rcc_pkg::HUE_PURPLE;
      if (gd > thr_wrise) return rcc_pkg::HUE_YELLOW;
      if (gd > -thr_mfall) return rcc_pkg::HUE_ORANGE;
      return rcc_pkg::HUE_RED;
    end
    if (gd == mx && gd > thr_srise) begin
      if (bd > thr_wrise) return rcc_pkg::HUE_CYAN;
      if (rd > thr_wrise) return rcc_pkg::HUE_YELLOW;
      return rcc_pkg::HUE_GREEN;
    end
    if (bd == mx && bd > thr_srise) begin
      if (rd > thr_wrise) return rcc_pkg::HUE_PURPLE;
      if (gd > thr_wrise) return rcc_pkg::HUE_CYAN;
      return rcc_pkg::HUE_BLUE;
    end
    mn = (rd < gd) ? rd : gd;
    if (bd < mn) mn = bd;
    // Dominant drop: blue, then green, then red
    if (bd == mn && bd < -thr_sfall) begin
      if (rd > gd && rd > thr_wrise) return rcc_pkg::HUE_ORANGE;
      if (gd > rd && gd > thr_wrise) return rcc_pkg::HUE_GREEN;
      if (rd > 0 && gd > 0) return rcc_pkg::HUE_YELLOW;
      return rcc_pkg::HUE_ORANGE;
    end
    if (gd == mn && gd < -thr_sfall) begin
      if (rd > bd) return rcc_pkg::HUE_RED;
      if (bd > rd) return rcc_pkg::HUE_BLUE;
      return rcc_pkg::HUE_PURPLE;
    end
    if (rd == mn && rd < -thr_sfall) begin
      if (gd > bd) return rcc_pkg::HUE_GREEN;
      if (bd > gd) return rcc_pkg::HUE_BLUE;
      return rcc_pkg::HUE_CYAN;
    end
    return rcc_pkg::HUE_NONE;
  endfunction

  // Accumulate one calibration sample; returns 1 when the run ends
  function automatic bit calibration_step(input longint r, g, b, w);
    longint total;
    if (w > rcc_pkg::CAL_WHITE_FLOOR && r > rcc_pkg::CAL_RG_FLOOR &&
        g > rcc_pkg::CAL_RG_FLOOR && b > rcc_pkg::CAL_B_FLOOR) begin
      total = r + g + b;
      acc_r += share(r, total);
      acc_g += share(g, total);
      acc_b += share(b, total);
      run_ok++;
    end
    run_pos++;
    if (run_pos < RUN_LEN) return 1'b0;
    if (run_ok >= RUN_MIN_OK) begin
      base_r = acc_r / run_ok;
      base_g = acc_g / run_ok;
      base_b = acc_b / run_ok;
      is_calibrated = 1'b1;
    end
    acc_r = 0; acc_g = 0; acc_b = 0;
    run_pos = 0; run_ok = 0;
    return 1'b1;
  endfunction

  function automatic verdict_t predict_reading(input reading_t rd);
    verdict_t v;
    v.color = rcc_pkg::HUE_NONE;
    v.run_done = 1'b0;
    if (rd.op == rcc_pkg::OP_CLASSIFY)
      v.color = predict_color(rd.red, rd.green, rd.blue, rd.white);
    else v.run_done = calibration_step(rd.red, rd.green, rd.blue, rd.white);
    v.calibrated = is_calibrated;
    return v;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send(input reading_t rd);
    verdict_t v;
    s_tvalid <= 1'b1;
    s_tuser  <= rd.op;
    s_tdata  <= {rd.white, rd.blue, rd.green, rd.red};
    do @(posedge clk); while (!s_tready);
    v = predict_reading(rd);
    if (rd.typed) v.color = rd.color;
    verdict_q.push_back(v);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write all seven thresholds plus an ignored out-of-range index
  task automatic set_thresholds(input longint v[7]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= (i < 7) ? v[i][17:0] : 18'h3FFFF;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    thr_white = v[rcc_pkg::REG_WHITE_MIN];
    thr_peak  = v[rcc_pkg::REG_PEAK_MIN];
    thr_sat   = v[rcc_pkg::REG_SATURATION_MIN];
    thr_srise = v[rcc_pkg::REG_STRONG_RISE];
    thr_wrise = v[rcc_pkg::REG_WEAK_RISE];
    thr_mfall = v[rcc_pkg::REG_MILD_FALL];
    thr_sfall = v[rcc_pkg::REG_STRONG_FALL];
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 200));
      1: return 16'($urandom_range(0, 4000));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(20000, 65535));
    endcase
  endfunction

  // Random traffic: calibration runs, realistic readings, and noise
  task automatic random_items(input int n);
    reading_t rd;
    int k, base;
    k = 0;
    while (k < n) begin
      rd.typed = 1'b0;
      rd.color = rcc_pkg::HUE_NONE;
      if ($urandom_range(99) < 20) begin
        for (int j = 0; j < RUN_LEN; j++) begin
          base = $urandom_range(40, 20000);
          rd.op    = rcc_pkg::OP_CALIBRATE;
          rd.red   = 16'(base * $urandom_range(30, 50) / 40);
          rd.green = 16'(base * $urandom_range(30, 50) / 40);
          rd.blue  = 16'(base * $urandom_range(15, 30) / 40);
          rd.white = 16'(base * 2);
          if ($urandom_range(99) < 25) rd.blue = 16'($urandom_range(0, 12));
          if ($urandom_range(99) < 10) rd.white = 16'($urandom_range(95, 105));
          // Occasionally interleave a classify reading within the run
          if ($urandom_range(99) < 10) rd.op = rcc_pkg::OP_CLASSIFY;
          send(rd);
          k++;
        end
      end else begin
        rd.op = ($urandom_range(99) < 10) ? rcc_pkg::OP_CALIBRATE : rcc_pkg::OP_CLASSIFY;
        if ($urandom_range(99) < 70) begin
          base = $urandom_range(30, 16000);
          rd.red   = 16'(base * $urandom_range(0, 60) / 30);
          rd.green = 16'(base * $urandom_range(0, 60) / 30);
          rd.blue  = 16'(base * $urandom_range(0, 60) / 30);
          rd.white = ($urandom_range(0, 99) < 90) ? 16'(base * 3)
                                                  : 16'($urandom_range(0, 150));
        end else begin
          rd.red = rand_count(); rd.green = rand_count();
          rd.blue = rand_count(); rd.white = rand_count();
        end
        send(rd);
        k++;
      end
    end
  endtask

  // Result check and receiver backpressure
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report("unexpected result", m_tdata, 0);
      end else begin
        v = verdict_q.pop_front();
        if (m_tdata[2:0] !== v.color) report("color", m_tdata[2:0], v.color);
        if (m_tdata[3] !== v.calibrated) report("baseline_calibrated", m_tdata[3], v.calibrated);
        if (m_tdata[4] !== v.run_done) report("calibration_done", m_tdata[4], v.run_done);
        if (m_tdata[7:5] !== 3'b000) report("zero fill", m_tdata[7:5], 0);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  reading_t directed[25];
  longint   thr_set[7];

  initial begin
    cycles = 0; errors = 0; hold_cycles = 0;
    idle_pct = 0; stall_pct = 0;
    clk = 1'b0; rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = rcc_pkg::OP_CLASSIFY;
    m_tready = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    thr_white = 100; thr_peak = 30; thr_sat = 1638;
    thr_srise = 328; thr_wrise = 197; thr_mfall = 655; thr_sfall = 524;
    base_r = 26214; base_g = 25559; base_b = 13763;
    acc_r = 0; acc_g = 0; acc_b = 0; run_pos = 0; run_ok = 0; is_calibrated = 1'b0;

    // Directed readings with default thresholds and baseline
    directed = '{
      '{rcc_pkg::OP_CLASSIFY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd1000, 16'd1000, 16'd1000, 16'd99, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd29, 16'd5, 16'd29, 16'd1000, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd400, 16'd390, 16'd210, 16'd500, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd2000, 16'd500, 16'd300, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd500, 16'd2000, 16'd300, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd300, 16'd500, 16'd2000, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd1500, 16'd300, 16'd1500, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd1500, 16'd1500, 16'd100, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd1000, 16'd1000, 16'd50, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd1000, 16'd200, 16'd1000, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd100, 16'd1000, 16'd1000, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd500, 16'd400, 16'd300, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd520, 16'd410, 16'd290, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd2000, 16'd500, 16'd300, 16'd500, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd510, 16'd400, 16'd10, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd480, 16'd390, 16'd310, 16'd101, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd31, 16'd31, 16'd11, 16'd101, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd500, 16'd500, 16'd300, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd490, 16'd400, 16'd300, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CALIBRATE, 16'd30, 16'd400, 16'd300, 16'd900, 1'b1, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd500, 16'd400, 16'd300, 16'd900, 1'b0, rcc_pkg::HUE_NONE},
      '{rcc_pkg::OP_CLASSIFY, 16'd300, 16'd300, 16'd900, 16'd900, 1'b0, rcc_pkg::HUE_NONE}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i]);
    // Failed run: dark samples leave the baseline alone
    for (int i = 0; i < RUN_LEN; i++)
      send('{rcc_pkg::OP_CALIBRATE, 16'd500, 16'd500, 16'd500, 16'd100, 1'b0,
             rcc_pkg::HUE_NONE});
    drain();

    // All thresholds at zero, including a zero-total reading
    thr_set = '{0, 0, 0, 0, 0, 0, 0};
    set_thresholds(thr_set);
    send('{rcc_pkg::OP_CLASSIFY, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, rcc_pkg::HUE_NONE});
    random_items(100);
    drain();

    // Thresholds at their 16-bit maximum, saturation minimum at 131072
    thr_set = '{65535, 65535, 131072, 65535, 65535, 65535, 65535};
    set_thresholds(thr_set);
    random_items(60);
    drain();

    // Back to the defaults with no idling
    thr_set = '{100, 30, 1638, 328, 197, 655, 524};
    set_thresholds(thr_set);
    random_items(400);
    drain();

    // Random thresholds, sender idling
    thr_set = '{$urandom_range(0, 400), $urandom_range(0, 200), $urandom_range(0, 6000),
                $urandom_range(0, 2000), $urandom_range(0, 1000), $urandom_range(0, 2000),
                $urandom_range(0, 2000)};
    set_thresholds(thr_set);
    idle_pct = 74; stall_pct = 0;
    random_items(350);
    drain();

    // Receiver stalling, with one long hold-off that backs up the input
    idle_pct = 0; stall_pct = 74;
    hold_cycles = 4000;
    random_items(350);
    drain();

    // Both sides idling
    thr_set = '{100, 30, 1638, 328, 197, 655, 524};
    set_thresholds(thr_set);
    idle_pct = 15; stall_pct = 15;
    random_items(500);
    drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rcc_pkg.sv
rtl/rcc_front.sv
rtl/rcc_queue.sv
rtl/rcc_divider.sv
rtl/rcc_back.sv
rtl/rgb_color_classifier_baseline_unit.sv
verif/tb_rgb_color_classifier_baseline_unit.sv
